>>> hdl/scba_pkg.sv
// Package: constants, codes and helpers of the size class block allocator.
package scba_pkg;

    localparam int NumClasses  = 16;
    localparam int StackDepth  = 4096;
    localparam int ArenaBytes  = 1048576;
    localparam int NumSlots    = ArenaBytes / 16;
    localparam int ClsW        = 4;
    localparam int HtW         = 13;
    localparam int SlotW       = 16;
    localparam int OffW        = 21;
    localparam int StkAw       = ClsW + 12;
    localparam int AddrW       = 1;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_ADDREF  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_POOL     = 4'd0,
        ST_ARENA    = 4'd1,
        ST_EXTERNAL = 4'd2,
        ST_OVERSIZE = 4'd3,
        ST_REFADDED = 4'd4,
        ST_STILL    = 4'd5,
        ST_OWNPOOL  = 4'd6,
        ST_SMALLER  = 4'd7,
        ST_DROPPED  = 4'd8,
        ST_UNMANAGED= 4'd9,
        ST_SATURATE = 4'd10
    } t_status;

    localparam logic [AddrW-1:0] REG_BASE  = 1'b0;
    localparam logic [AddrW-1:0] REG_LIMIT = 1'b1;

endpackage

>>> hdl/size_class_block_allocator.sv
// Top level: size class block allocator with header and free stack memories.
// A command passes through read, wait and execute states to its result strobe; a pool
// hit also waits for the 20-step quotient divider, and a release that frees the block
// probes stacks one at a time, own class first. One command at a time: busy is high
// until the result strobe; results cannot be stalled. Reset clears stack heights, bump
// offset, base and valid, sets the limit to the arena size; memories are not cleared.
module size_class_block_allocator
    import scba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_element_count,
    input  logic [15:0] i_element_size,
    input  logic [31:0] i_block_addr,
    input  logic        i_realtime_caller,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [31:0] o_granted_addr,
    output logic [15:0] o_granted_elements,
    output logic [3:0]  o_size_class,
    output logic [15:0] o_users_left
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_WAIT  = 6'b000100,
        S_EXEC  = 6'b001000,
        S_PROBE = 6'b010000,
        S_DIV   = 6'b100000
    } t_state;

    // Memories: free stacks and block headers
    logic [15:0] stk_mem [0:NumClasses*StackDepth-1];
    logic [19:0] hdr_mem [0:NumSlots-1];
    logic [15:0] r_stk_rd;
    logic [19:0] r_hdr_rd;
    logic        stk_we, hdr_we;
    logic [StkAw-1:0] stk_wa, stk_ra;
    logic [SlotW-1:0] hdr_wa, hdr_ra;
    logic [15:0] stk_wd;
    logic [19:0] hdr_wd;

    always_ff @(posedge i_clk) begin
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        r_stk_rd <= stk_mem[stk_ra];
    end
    always_ff @(posedge i_clk) begin
        if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
        r_hdr_rd <= hdr_mem[hdr_ra];
    end

    t_state r_state, n_state;
    logic [31:0] r_base, n_base;
    logic [20:0] r_limit, n_limit;
    logic [NumClasses-1:0][HtW-1:0] r_ht, n_ht;
    logic [OffW-1:0] r_bump, n_bump;
    t_cmd  r_cmd, n_cmd;
    logic [15:0] r_cnt, n_cnt, r_esz, n_esz;
    logic        r_rt, n_rt;
    logic [31:0] r_size, n_size;
    logic        r_over, n_over;
    logic [3:0]  r_cls, n_cls, r_probe, n_probe;
    logic        r_unm, n_unm;
    logic [SlotW-1:0] r_slot, n_slot;
    logic        r_valid, n_valid;
    logic [3:0]  r_st, n_st, r_ocls, n_ocls;
    logic [31:0] r_oaddr, n_oaddr;
    logic [15:0] r_oel, n_oel, r_ousers, n_ousers;

    // Configuration port
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2 +: AddrW])
            REG_BASE:  prdata = r_base;
            REG_LIMIT: prdata = {11'd0, r_limit};
            default:   prdata = 32'd0;
        endcase
    end

    // Request size in bytes
    logic [31:0] w_prod;
    assign w_prod = {16'd0, i_element_count} * {16'd0, i_element_size};

    // Class selection from the registered size
    logic [3:0] w_cls;
    always_comb begin
        w_cls = 4'd15;
        for (int c = 14; c >= 0; c--)
            if (r_size <= (32'd16 << c)) w_cls = 4'(c);
    end

    // Address check for reference commands
    logic [31:0] w_off;
    assign w_off = i_block_addr - r_base;
    logic [31:0] w_offm;
    assign w_offm = w_off - 32'd16;

    logic [20:0] w_lim, w_need;
    logic [21:0] w_end;
    assign w_lim  = (r_limit > 21'(ArenaBytes)) ? 21'(ArenaBytes) : r_limit;
    assign w_need = 21'd16 + (21'd16 << r_cls);
    assign w_end  = {1'b0, r_bump} + {1'b0, w_need};

    logic [3:0] w_hcls;
    logic [15:0] w_husers;
    assign w_hcls   = r_hdr_rd[3:0];
    assign w_husers = r_hdr_rd[19:4];

    logic div_start, div_done;
    logic [15:0] div_q;
    scba_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (20'd16 << r_cls),
        .i_den  (r_esz),
        .o_done (div_done),
        .o_quot (div_q)
    );

    assign busy = (r_state != S_IDLE);

    // Memory addressing: stack top of the chosen class, header of the current slot
    logic [HtW-1:0] w_htc;
    assign w_htc  = r_ht[r_cls];
    assign stk_ra = {r_cls, 12'(w_htc - 13'd1)};
    assign hdr_ra = r_slot;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_limit  = r_limit;
        n_ht     = r_ht;
        n_bump   = r_bump;
        n_cmd    = r_cmd;
        n_cnt    = r_cnt;
        n_esz    = r_esz;
        n_rt     = r_rt;
        n_size   = r_size;
        n_over   = r_over;
        n_cls    = r_cls;
        n_probe  = r_probe;
        n_unm    = r_unm;
        n_slot   = r_slot;
        n_valid  = 1'b0;
        n_st     = r_st;
        n_ocls   = r_ocls;
        n_oaddr  = r_oaddr;
        n_oel    = r_oel;
        n_ousers = r_ousers;
        stk_we   = 1'b0;
        stk_wa   = '0;
        stk_wd   = 16'd0;
        hdr_we   = 1'b0;
        hdr_wa   = '0;
        hdr_wd   = 20'd0;
        div_start = 1'b0;
        if (psel && penable && pwrite && pready) begin
            unique case (paddr[2 +: AddrW])
                REG_BASE:  n_base  = pwdata;
                REG_LIMIT: n_limit = pwdata[20:0];
                default:   ;
            endcase
        end
        unique case (r_state)
            S_IDLE: begin
                if (start && (t_cmd'(i_cmd) != CMD_NONE)) begin
                    n_cmd  = t_cmd'(i_cmd);
                    n_cnt  = i_element_count;
                    n_esz  = i_element_size;
                    n_rt   = i_realtime_caller;
                    n_size = w_prod;
                    n_slot = w_offm[19:4];
                    n_unm  = (w_off < 32'd16) || (w_off[3:0] != 4'd0)
                             || (w_offm >= {11'd0, r_bump});
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_over  = (r_size > 32'd524288);
                n_cls   = (r_cmd == CMD_ALLOC) ? w_cls : 4'd0;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                // stack top of the chosen class is read; header read holds
                n_state = S_EXEC;
            end
            S_DIV: begin
                if (div_done) begin
                    hdr_we   = 1'b1;
                    hdr_wa   = r_slot;
                    hdr_wd   = {16'd1, r_hdr_rd[3:0]};
                    n_valid  = 1'b1;
                    n_st     = ST_POOL;
                    n_oaddr  = r_base + {12'd0, r_slot, 4'd0} + 32'd16;
                    n_oel    = (r_esz == 16'd0) ? 16'hFFFF : div_q;
                    n_ocls   = r_cls;
                    n_ousers = 16'd0;
                    n_state  = S_IDLE;
                end
            end
            S_EXEC: begin
                n_valid  = 1'b1;
                n_oaddr  = 32'd0;
                n_oel    = 16'd0;
                n_ocls   = 4'd0;
                n_ousers = 16'd0;
                n_state  = S_IDLE;
                if (r_cmd == CMD_ALLOC) begin
                    n_oel = r_cnt;
                    if (r_over) begin
                        n_st = ST_OVERSIZE;
                    end else if (r_ht[r_cls] != '0) begin
                        // pop the stack top and start the quotient
                        n_valid   = 1'b0;
                        n_slot    = r_stk_rd;
                        n_ht[r_cls] = r_ht[r_cls] - 13'd1;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else if (r_rt && w_end <= {1'b0, w_lim}) begin
                        hdr_we  = 1'b1;
                        hdr_wa  = r_bump[19:4];
                        hdr_wd  = {16'd1, r_cls};
                        n_bump  = w_end[20:0];
                        n_st    = ST_ARENA;
                        n_oaddr = r_base + {11'd0, r_bump} + 32'd16;
                        n_ocls  = r_cls;
                    end else begin
                        n_st   = ST_EXTERNAL;
                        n_ocls = r_cls;
                    end
                end else if (r_unm || (r_cmd == CMD_RELEASE && w_husers == 16'd0)) begin
                    n_st = ST_UNMANAGED;
                end else if (r_cmd == CMD_ADDREF) begin
                    if (w_husers == 16'hFFFF) begin
                        n_ousers = w_husers;
                        n_st     = ST_SATURATE;
                    end else begin
                        n_ousers = w_husers + 16'd1;
                        n_st     = ST_REFADDED;
                        hdr_we   = 1'b1;
                        hdr_wa   = r_slot;
                        hdr_wd   = {w_husers + 16'd1, w_hcls};
                    end
                end else begin
                    hdr_we   = 1'b1;
                    hdr_wa   = r_slot;
                    hdr_wd   = {w_husers - 16'd1, w_hcls};
                    n_ousers = w_husers - 16'd1;
                    n_ocls   = w_hcls;
                    if (w_husers != 16'd1) begin
                        n_st = ST_STILL;
                    end else begin
                        n_valid = 1'b0;
                        n_probe = w_hcls;
                        n_cls   = w_hcls;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                // try own class first, then each smaller class
                if (r_ht[r_probe] < 13'(StackDepth)) begin
                    stk_we  = 1'b1;
                    stk_wa  = {r_probe, r_ht[r_probe][11:0]};
                    stk_wd  = r_slot;
                    n_ht[r_probe] = r_ht[r_probe] + 13'd1;
                    n_valid = 1'b1;
                    n_st    = (r_probe == r_cls) ? ST_OWNPOOL : ST_SMALLER;
                    n_ocls  = r_probe;
                    n_state = S_IDLE;
                end else if (r_probe == 4'd0) begin
                    n_valid = 1'b1;
                    n_st    = ST_DROPPED;
                    n_ocls  = r_cls;
                    n_state = S_IDLE;
                end else begin
                    n_probe = r_probe - 4'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= 32'd0;
            r_limit <= 21'd1048576;
            r_bump  <= '0;
            r_ht    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_limit <= n_limit;
            r_bump  <= n_bump;
            r_ht    <= n_ht;
            r_valid <= n_valid;
        end
    end

    // Hold the command and result fields
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cnt    <= n_cnt;
        r_esz    <= n_esz;
        r_rt     <= n_rt;
        r_size   <= n_size;
        r_over   <= n_over;
        r_cls    <= n_cls;
        r_probe  <= n_probe;
        r_unm    <= n_unm;
        r_slot   <= n_slot;
        r_st     <= n_st;
        r_ocls   <= n_ocls;
        r_oaddr  <= n_oaddr;
        r_oel    <= n_oel;
        r_ousers <= n_ousers;
    end

    assign o_valid            = r_valid;
    assign o_status           = r_st;
    assign o_granted_addr     = r_oaddr;
    assign o_granted_elements = r_oel;
    assign o_size_class       = r_ocls;
    assign o_users_left       = r_ousers;
endmodule

>>> hdl/scba_divider.sv
// Module: sequential restoring divider for class bytes over element size.
module scba_divider
    import scba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic [19:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [16:0] w_trial;

    // Shift one quotient bit a cycle
    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = 17'd0;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = 17'd0;
            n_cnt  = 5'd20;
            n_busy = 1'b1;
        end else if (r_busy) begin
            w_trial = {r_rem[15:0], r_q[19]};
            n_q = {r_q[18:0], 1'b0};
            if (w_trial >= {1'b0, i_den}) begin
                n_rem  = w_trial - {1'b0, i_den};
                n_q[0] = 1'b1;
            end else begin
                n_rem = w_trial;
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = (r_q[19:16] != 4'd0) ? 16'hFFFF : r_q[15:0];
endmodule

>>> hdl/scba_checker.sv
// Checker: port-level properties of the size class block allocator.
module scba_checker
    import scba_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_cmd,
    input logic        o_valid,
    input logic [3:0]  o_status,
    input logic [31:0] o_granted_addr
);
    // A result ends the command
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    // A taken command raises busy
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd != CMD_NONE) |=> busy) else $error("command not taken");
    // Status stays in range
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_SATURATE) else $error("bad status");
    // Only grants carry an address
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_POOL && o_status != ST_ARENA)
        |-> o_granted_addr == 32'd0)
        else $error("stray address");
endmodule

bind size_class_block_allocator scba_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
    .o_valid(o_valid), .o_status(o_status), .o_granted_addr(o_granted_addr)
);
